// ===== sv/bsc_pkg.sv =====
// Shared types and constants for the banker's algorithm safety check.
// Used by the channel interfaces, the top level and the checker.
`default_nettype none

package bsc_pkg;

    // Default sizing of the tables
    localparam int MAX_PROCESSES_DEF = 8;
    localparam int MAX_RESOURCES_DEF = 4;

    // Payload field widths
    localparam int COMMAND_W        = 2;
    localparam int PROCESS_INDEX_W  = 3;
    localparam int RESOURCE_INDEX_W = 2;
    localparam int AMOUNT_W         = 8;
    localparam int PROCESS_ID_W     = 3;

    // Configuration register widths and port widths
    localparam int PROCESS_COUNT_W  = 4;
    localparam int RESOURCE_COUNT_W = 3;
    localparam int CFG_INDEX_W      = 1;
    localparam int CFG_DATA_W       = 4;

    localparam logic [PROCESS_COUNT_W-1:0]  PROCESS_COUNT_RST  = 4'd8;
    localparam logic [RESOURCE_COUNT_W-1:0] RESOURCE_COUNT_RST = 3'd4;

    // Working available counts saturate at the top of a 12-bit count
    localparam int                WORK_W      = 12;
    localparam logic [WORK_W-1:0] AVAIL_LIMIT = 12'd4095;

    typedef enum logic [COMMAND_W-1:0] {
        CMD_LOAD_ALLOC = 2'd0,
        CMD_LOAD_MAX   = 2'd1,
        CMD_LOAD_AVAIL = 2'd2,
        CMD_CHECK      = 2'd3
    } cmd_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PROCESS_COUNT  = 1'b0,
        CFG_RESOURCE_COUNT = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_PSEL,
        ST_FETCH,
        ST_TEST,
        ST_AFETCH,
        ST_ADD,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

// ===== sv/bsc_if.sv =====
// Valid/ready channel interfaces for the safety check: items, results, config writes.
// Depends on bsc_pkg for field widths.
`default_nettype none

interface bsc_item_if;
    logic                                   valid;
    logic                                   ready;
    logic [bsc_pkg::COMMAND_W-1:0]          command;
    logic [bsc_pkg::PROCESS_INDEX_W-1:0]    process_index;
    logic [bsc_pkg::RESOURCE_INDEX_W-1:0]   resource_index;
    logic [bsc_pkg::AMOUNT_W-1:0]           amount;

    modport source (output valid, command, process_index, resource_index, amount,
                    input ready);
    modport sink   (input valid, command, process_index, resource_index, amount,
                    output ready);
endinterface

interface bsc_result_if;
    logic                               valid;
    logic                               ready;
    logic                               safe;
    logic [bsc_pkg::PROCESS_ID_W-1:0]   process_id;
    logic                               last;

    modport source (output valid, safe, process_id, last, input ready);
    modport sink   (input valid, safe, process_id, last, output ready);
endinterface

interface bsc_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [bsc_pkg::CFG_INDEX_W-1:0]    index;
    logic [bsc_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== sv/bsc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the allocation and maximum-claim tables.
`default_nettype none

module bsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                                    clk,
    input  wire logic                                    wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                        wr_data,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output      logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write on enable, register the read every cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== sv/bankers_safety_check.sv =====
// Top level of the banker's algorithm safety check: sequencer, counters and one shared adder.
// Depends on bsc_pkg, bsc_if (channel interfaces) and bsc_ram (table storage).
`default_nettype none

// Load items (allocation, maximum claim, available count) are written directly and
// produce no result. A check item starts a search on a working copy of the available
// counts: the sequencer walks the processes in index order, pass after pass, and
// pushes every resource comparison and every add-back through a single 13-bit adder
// fed by the registered read of the two table RAMs. Each resource step is a RAM read,
// then the adder. With np processes in use, at most np passes run.
// The results then leave one per cycle while the sink is ready: the safe sequence,
// one process per beat with last on the final one, or a single beat with safe low.
// Item ready is held low from the check until its last result beat is taken.
// Configuration writes are taken at any time.
module bankers_safety_check #(
    parameter int MAX_PROCESSES = bsc_pkg::MAX_PROCESSES_DEF,
    parameter int MAX_RESOURCES = bsc_pkg::MAX_RESOURCES_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    bsc_cfg_if.sink         cfg,
    bsc_item_if.sink        item,
    bsc_result_if.source    result
);

    localparam int PW    = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int RW    = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
    localparam int PCW   = $clog2(MAX_PROCESSES + 1);
    localparam int RCW   = $clog2(MAX_RESOURCES + 1);
    localparam int AW    = PW + RW;
    localparam int DEPTH = 2 ** AW;
    localparam int SW    = bsc_pkg::WORK_W + 1;

    // Control state
    bsc_pkg::state_t state_reg;
    bsc_pkg::state_t state_next;

    logic [bsc_pkg::PROCESS_COUNT_W-1:0]  pc_reg;
    logic [bsc_pkg::RESOURCE_COUNT_W-1:0] rc_reg;
    logic [PCW-1:0]                       np_reg;
    logic [RCW-1:0]                       nr_reg;
    logic [PCW-1:0]                       i_reg;
    logic [RW-1:0]                        r_reg;
    logic [PCW-1:0]                       done_reg;
    logic [PCW-1:0]                       k_reg;
    logic                                 progress_reg;
    logic                                 unsafe_reg;
    logic [MAX_PROCESSES-1:0]             finished_reg;

    // Payload storage
    logic [bsc_pkg::AMOUNT_W-1:0]     avail_reg [MAX_RESOURCES];
    logic [bsc_pkg::WORK_W-1:0]       work_reg  [MAX_RESOURCES];
    logic [bsc_pkg::PROCESS_ID_W-1:0] seq_reg   [MAX_PROCESSES];

    // Handshake and decode
    logic           item_fire;
    logic           result_fire;
    bsc_pkg::cmd_t  cmd;
    logic           pidx_ok;
    logic           ridx_ok;
    logic [PW-1:0]  load_pidx;
    logic [RW-1:0]  load_ridx;
    logic [AW-1:0]  wr_addr;
    logic [AW-1:0]  rd_addr;
    logic           alloc_wr_en;
    logic           max_wr_en;
    logic [bsc_pkg::AMOUNT_W-1:0] alloc_rd;
    logic [bsc_pkg::AMOUNT_W-1:0] max_rd;

    // Shared adder and loop conditions
    logic [SW-1:0]              sum;
    logic                       fits;
    logic [bsc_pkg::WORK_W-1:0] sat;
    logic                       r_last;
    logic                       i_end;
    logic                       all_done;
    logic                       finished_cur;
    logic                       k_last;
    logic [PCW-1:0]             np_clamp;
    logic [RCW-1:0]             nr_clamp;

    // Decode the item beat
    assign item_fire   = item.valid && item.ready;
    assign result_fire = result.valid && result.ready;
    assign cmd         = bsc_pkg::cmd_t'(item.command);
    assign pidx_ok     = 32'(item.process_index) < MAX_PROCESSES;
    assign ridx_ok     = 32'(item.resource_index) < MAX_RESOURCES;
    assign load_pidx   = PW'(item.process_index);
    assign load_ridx   = RW'(item.resource_index);
    assign wr_addr     = {load_pidx, load_ridx};
    assign rd_addr     = {i_reg[PW-1:0], r_reg};
    assign alloc_wr_en = item_fire && (cmd == bsc_pkg::CMD_LOAD_ALLOC) && pidx_ok && ridx_ok;
    assign max_wr_en   = item_fire && (cmd == bsc_pkg::CMD_LOAD_MAX) && pidx_ok && ridx_ok;

    bsc_ram #(
        .WIDTH (bsc_pkg::AMOUNT_W),
        .DEPTH (DEPTH)
    ) u_alloc_ram (
        .clk     (clk),
        .wr_en   (alloc_wr_en),
        .wr_addr (wr_addr),
        .wr_data (item.amount),
        .rd_addr (rd_addr),
        .rd_data (alloc_rd)
    );

    bsc_ram #(
        .WIDTH (bsc_pkg::AMOUNT_W),
        .DEPTH (DEPTH)
    ) u_max_ram (
        .clk     (clk),
        .wr_en   (max_wr_en),
        .wr_addr (wr_addr),
        .wr_data (item.amount),
        .rd_addr (rd_addr),
        .rd_data (max_rd)
    );

    // One adder: allocation plus working count, used for the fit test and the add-back
    assign sum  = {{(SW - bsc_pkg::AMOUNT_W){1'b0}}, alloc_rd} + {1'b0, work_reg[r_reg]};
    assign fits = {{(SW - bsc_pkg::AMOUNT_W){1'b0}}, max_rd} <= sum;
    assign sat  = (sum > {1'b0, bsc_pkg::AVAIL_LIMIT}) ? bsc_pkg::AVAIL_LIMIT
                                                        : sum[bsc_pkg::WORK_W-1:0];

    // Loop bounds
    assign r_last       = (RCW'(r_reg) + RCW'(1)) == nr_reg;
    assign i_end        = i_reg == np_reg;
    assign all_done     = done_reg == np_reg;
    assign finished_cur = finished_reg[i_reg[PW-1:0]];
    assign k_last       = (k_reg + PCW'(1)) == np_reg;

    // Saturate the register counts into the supported range
    always_comb
    begin
        if (pc_reg == '0)
        begin
            np_clamp = PCW'(1);
        end
        else if (32'(pc_reg) > MAX_PROCESSES)
        begin
            np_clamp = PCW'(MAX_PROCESSES);
        end
        else
        begin
            np_clamp = PCW'(pc_reg);
        end

        if (rc_reg == '0)
        begin
            nr_clamp = RCW'(1);
        end
        else if (32'(rc_reg) > MAX_RESOURCES)
        begin
            nr_clamp = RCW'(MAX_RESOURCES);
        end
        else
        begin
            nr_clamp = RCW'(rc_reg);
        end
    end

    // Next state of the sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bsc_pkg::ST_IDLE:
            begin
                if (item_fire && (cmd == bsc_pkg::CMD_CHECK))
                begin
                    state_next = bsc_pkg::ST_INIT;
                end
            end
            bsc_pkg::ST_INIT:
            begin
                state_next = bsc_pkg::ST_PSEL;
            end
            bsc_pkg::ST_PSEL:
            begin
                if (i_end)
                begin
                    if (all_done || !progress_reg)
                    begin
                        state_next = bsc_pkg::ST_EMIT;
                    end
                end
                else if (!finished_cur)
                begin
                    state_next = bsc_pkg::ST_FETCH;
                end
            end
            bsc_pkg::ST_FETCH:
            begin
                state_next = bsc_pkg::ST_TEST;
            end
            bsc_pkg::ST_TEST:
            begin
                if (!fits)
                begin
                    state_next = bsc_pkg::ST_PSEL;
                end
                else if (r_last)
                begin
                    state_next = bsc_pkg::ST_AFETCH;
                end
                else
                begin
                    state_next = bsc_pkg::ST_FETCH;
                end
            end
            bsc_pkg::ST_AFETCH:
            begin
                state_next = bsc_pkg::ST_ADD;
            end
            bsc_pkg::ST_ADD:
            begin
                state_next = r_last ? bsc_pkg::ST_PSEL : bsc_pkg::ST_AFETCH;
            end
            bsc_pkg::ST_EMIT:
            begin
                if (result_fire && result.last)
                begin
                    state_next = bsc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bsc_pkg::ST_IDLE;
            end
        endcase
    end

    // Handshake outputs and the result beat
    always_comb
    begin
        cfg.ready         = 1'b1;
        item.ready        = (state_reg == bsc_pkg::ST_IDLE);
        result.valid      = (state_reg == bsc_pkg::ST_EMIT);
        result.safe       = !unsafe_reg;
        result.process_id = unsafe_reg ? '0 : seq_reg[k_reg[PW-1:0]];
        result.last       = unsafe_reg || k_last;
    end

    // Advance the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bsc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Configuration registers, counters and flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg       <= bsc_pkg::PROCESS_COUNT_RST;
            rc_reg       <= bsc_pkg::RESOURCE_COUNT_RST;
            np_reg       <= '0;
            nr_reg       <= '0;
            i_reg        <= '0;
            r_reg        <= '0;
            done_reg     <= '0;
            k_reg        <= '0;
            progress_reg <= 1'b0;
            unsafe_reg   <= 1'b0;
            finished_reg <= '0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (bsc_pkg::cfg_idx_t'(cfg.index))
                    bsc_pkg::CFG_PROCESS_COUNT:
                    begin
                        pc_reg <= cfg.data[bsc_pkg::PROCESS_COUNT_W-1:0];
                    end
                    bsc_pkg::CFG_RESOURCE_COUNT:
                    begin
                        rc_reg <= cfg.data[bsc_pkg::RESOURCE_COUNT_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end

            case (state_reg)
                bsc_pkg::ST_IDLE:
                begin
                    if (item_fire && (cmd == bsc_pkg::CMD_CHECK))
                    begin
                        np_reg <= np_clamp;
                        nr_reg <= nr_clamp;
                    end
                end
                bsc_pkg::ST_INIT:
                begin
                    finished_reg <= '0;
                    i_reg        <= '0;
                    r_reg        <= '0;
                    done_reg     <= '0;
                    k_reg        <= '0;
                    progress_reg <= 1'b0;
                    unsafe_reg   <= 1'b0;
                end
                bsc_pkg::ST_PSEL:
                begin
                    if (i_end)
                    begin
                        if (!all_done && !progress_reg)
                        begin
                            unsafe_reg <= 1'b1;
                        end
                        else if (!all_done)
                        begin
                            // start another pass
                            i_reg        <= '0;
                            progress_reg <= 1'b0;
                        end
                    end
                    else if (finished_cur)
                    begin
                        i_reg <= i_reg + PCW'(1);
                    end
                    else
                    begin
                        r_reg <= '0;
                    end
                end
                bsc_pkg::ST_TEST:
                begin
                    if (!fits)
                    begin
                        i_reg <= i_reg + PCW'(1);
                    end
                    else if (r_last)
                    begin
                        r_reg <= '0;
                    end
                    else
                    begin
                        r_reg <= r_reg + RW'(1);
                    end
                end
                bsc_pkg::ST_ADD:
                begin
                    if (r_last)
                    begin
                        finished_reg[i_reg[PW-1:0]] <= 1'b1;
                        done_reg     <= done_reg + PCW'(1);
                        progress_reg <= 1'b1;
                        i_reg        <= i_reg + PCW'(1);
                    end
                    else
                    begin
                        r_reg <= r_reg + RW'(1);
                    end
                end
                bsc_pkg::ST_EMIT:
                begin
                    if (result_fire && !result.last)
                    begin
                        k_reg <= k_reg + PCW'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Available counts, working counts and the safe sequence
    always_ff @(posedge clk)
    begin
        if (item_fire && (cmd == bsc_pkg::CMD_LOAD_AVAIL) && ridx_ok)
        begin
            avail_reg[load_ridx] <= item.amount;
        end

        case (state_reg)
            bsc_pkg::ST_INIT:
            begin
                for (int r = 0; r < MAX_RESOURCES; r++)
                begin
                    work_reg[r] <= {{(bsc_pkg::WORK_W - bsc_pkg::AMOUNT_W){1'b0}},
                                    avail_reg[r]};
                end
            end
            bsc_pkg::ST_ADD:
            begin
                work_reg[r_reg] <= sat;
                if (r_last)
                begin
                    seq_reg[done_reg[PW-1:0]] <= bsc_pkg::PROCESS_ID_W'(i_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/bsc_checker.sv =====
// Port-level checker for the safety check, with its bind to the top level.
// Depends on bsc_pkg for the command codes.
`default_nettype none

module bsc_checker (
    input wire logic                                 clk,
    input wire logic                                 rst_n,
    input wire logic                                 item_valid,
    input wire logic                                 item_ready,
    input wire logic [bsc_pkg::COMMAND_W-1:0]        item_command,
    input wire logic                                 result_valid,
    input wire logic                                 result_ready,
    input wire logic                                 result_safe,
    input wire logic [bsc_pkg::PROCESS_ID_W-1:0]     result_process_id,
    input wire logic                                 result_last
);

    // Results only go out while no item is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !item_ready)
        else $error("result beat offered while item channel ready");

    // A check closes the item channel on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready && item_command == bsc_pkg::CMD_CHECK) |=> !item_ready)
        else $error("item channel still ready after a check beat");

    // A load returns to ready at once and causes no result
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready && item_command != bsc_pkg::CMD_CHECK)
            |=> (item_ready && !result_valid))
        else $error("load beat did not complete in one cycle");

    // An unsafe answer is a single beat with process zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_safe) |-> (result_last && result_process_id == '0))
        else $error("unsafe result not a single beat");

    // Nothing follows the final beat of a check
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_ready && result_last) |=> (!result_valid && item_ready))
        else $error("result beat after the last one");

endmodule

bind bankers_safety_check bsc_checker u_bsc_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .item_valid        (item.valid),
    .item_ready        (item.ready),
    .item_command      (item.command),
    .result_valid      (result.valid),
    .result_ready      (result.ready),
    .result_safe       (result.safe),
    .result_process_id (result.process_id),
    .result_last       (result.last)
);

`default_nettype wire
